>>> hdl/asf_pkg.sv
// Shared types, constants and helper functions for the acceleration smoothing filter.
// Used by asf_div, asf_dp, asf_ctrl and the top level; depends on nothing else.
`default_nettype none

package asf_pkg;

  // Fixed-point widths
  localparam int FRAC_W  = 17;  // unit fraction 0..65536
  localparam int WGT_W   = 17;  // tap weight, at most 65536
  localparam int MA_W    = 33;  // multiplier operand A, signed
  localparam int MB_W    = 18;  // multiplier operand B, signed (always non-negative)
  localparam int PROD_W  = MA_W + MB_W;
  localparam int ACC_W   = 56;
  localparam int DEN_W   = 20;  // divisor max(10*trim, 1.0)
  localparam int NUM_W   = 33;  // dividend f*65536 + d/2
  localparam int GAIN_W  = 21;
  localparam int NFULL_W = GAIN_W - 16;
  localparam int STEP_W  = 4;
  localparam int COEF_STEPS = 10;
  localparam int PADDR_W = 3;

  localparam logic [FRAC_W-1:0] ONE_Q16    = 17'd65536;
  localparam logic [MA_W-1:0]   WET_CUBE_K = 33'd3151762;  // 0.187859642462067 in Q.24

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  // Register indexes
  localparam logic REG_TRIM = 1'b0;
  localparam logic REG_WET  = 1'b1;

  // Multiplier operand selects
  typedef logic [3:0] mul_sel_t;
  localparam mul_sel_t MS_NONE = 4'd0;
  localparam mul_sel_t MS_TAP  = 4'd1;
  localparam mul_sel_t MS_FB   = 4'd2;
  localparam mul_sel_t MS_MIXL = 4'd3;
  localparam mul_sel_t MS_MIXX = 4'd4;
  localparam mul_sel_t MS_WW   = 4'd5;
  localparam mul_sel_t MS_W3   = 4'd6;
  localparam mul_sel_t MS_CK   = 4'd7;
  localparam mul_sel_t MS_TT   = 4'd8;
  localparam mul_sel_t MS_FF   = 4'd9;

  // Destination of a product; it is registered alongside the product and applied from the product register
  typedef logic [3:0] dst_t;
  localparam dst_t DST_NONE  = 4'd0;
  localparam dst_t DST_LOAD  = 4'd1;
  localparam dst_t DST_ADD   = 4'd2;
  localparam dst_t DST_PRIOR = 4'd3;
  localparam dst_t DST_W2    = 4'd4;
  localparam dst_t DST_W3    = 4'd5;
  localparam dst_t DST_C     = 4'd6;
  localparam dst_t DST_TT    = 4'd7;
  localparam dst_t DST_FF    = 4'd8;

  // Divider operand selects
  localparam logic DIV_FULL = 1'b0;
  localparam logic DIV_REM  = 1'b1;

  typedef struct packed {
    mul_sel_t mul_sel;
    dst_t     dst;
    logic     load_sample;
    logic     upd_vel;
    logic     upd_last;
    logic     out_load;
    logic     div_start;
    logic     div_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_status_t;

  // Saturate to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) begin
      r = S32_MAX[31:0];
    end else if (v < S32_MIN) begin
      r = S32_MIN[31:0];
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Map a 16-bit register to 0..65536 so that all ones is exactly 1.0
  function automatic logic [FRAC_W-1:0] unit_frac(input logic [15:0] r);
    return {1'b0, r} + {16'b0, r[15]};
  endfunction

endpackage

`default_nettype wire

>>> hdl/asf_div.sv
// Restoring divider, one quotient bit per cycle, for the tap weight computation.
// Depends on asf_pkg for operand widths.
`default_nettype none

module asf_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [asf_pkg::NUM_W-1:0]  dividend,
  input  wire logic [asf_pkg::DEN_W-1:0]  divisor,
  output logic                            done,
  output logic [asf_pkg::WGT_W-1:0]       quotient
);

  localparam int CNT_W = $clog2(asf_pkg::NUM_W + 1);

  logic                        busy_r;
  logic                        done_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [asf_pkg::DEN_W-1:0]   rem_r;
  logic [asf_pkg::NUM_W-1:0]   quo_r;
  logic [asf_pkg::DEN_W-1:0]   den_r;
  logic [asf_pkg::DEN_W:0]     shifted;
  logic [asf_pkg::DEN_W:0]     diff;
  logic                        ge;

  // Trial subtract of the divisor from the shifted partial remainder
  assign shifted = {rem_r, quo_r[asf_pkg::NUM_W-1]};
  assign ge      = shifted >= {1'b0, den_r};
  assign diff    = shifted - {1'b0, den_r};

  // Sequence control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(asf_pkg::NUM_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  // Shift the dividend out and the quotient in
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      den_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[asf_pkg::DEN_W-1:0] : shifted[asf_pkg::DEN_W-1:0];
      quo_r <= {quo_r[asf_pkg::NUM_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r[asf_pkg::WGT_W-1:0];

endmodule

`default_nettype wire

>>> hdl/asf_dp.sv
// Datapath: change line, shared multiplier with accumulator, coefficient registers,
// filter state and output register. Depends on asf_pkg and asf_div.
`default_nettype none

module asf_dp #(
  parameter int TAPS        = 20,
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire asf_pkg::dp_cmd_t              cmd,
  input  wire logic [$clog2(TAPS)-1:0]       tap_idx,
  input  wire logic [15:0]                   trim,
  input  wire logic [15:0]                   wet,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
  output asf_pkg::dp_status_t                status,
  output logic signed [SAMPLE_BITS-1:0]      sample_out
);

  localparam logic signed [63:0] OUT_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] OUT_MIN = -OUT_MAX - 64'sd1;

  // Filter state
  logic signed [31:0]                  line_r [TAPS];
  logic signed [31:0]                  last_r;
  logic signed [31:0]                  prior_r;
  logic signed [31:0]                  v_r;
  logic signed [SAMPLE_BITS-1:0]       x_r;
  logic signed [SAMPLE_BITS-1:0]       out_r;

  // Multiplier and accumulator
  logic signed [asf_pkg::MA_W-1:0]     mul_a;
  logic signed [asf_pkg::MB_W-1:0]     mul_b;
  logic signed [asf_pkg::PROD_W-1:0]   prod_c;
  logic signed [asf_pkg::PROD_W-1:0]   prod_r;
  logic signed [asf_pkg::ACC_W-1:0]    acc_r;
  asf_pkg::dst_t                       dst_d_r;

  // Coefficients
  logic [asf_pkg::FRAC_W-1:0]          t_frac;
  logic [asf_pkg::FRAC_W-1:0]          w_frac;
  logic [asf_pkg::FRAC_W-1:0]          w2_r;
  logic [asf_pkg::FRAC_W-1:0]          w3_r;
  logic [asf_pkg::FRAC_W-1:0]          c_r;
  logic [asf_pkg::FRAC_W-1:0]          tt_r;
  logic [asf_pkg::FRAC_W-1:0]          ff_r;
  logic [asf_pkg::WGT_W-1:0]           wfull_r;
  logic [asf_pkg::WGT_W-1:0]           wrem_r;
  logic [asf_pkg::NFULL_W-1:0]         nfull_r;
  logic                                div_sel_r;
  logic [asf_pkg::FRAC_W-1:0]          c_clip;
  logic [asf_pkg::FRAC_W-1:0]          one_minus_c;
  logic [asf_pkg::DEN_W-1:0]           overall;
  logic [asf_pkg::DEN_W-1:0]           den;
  logic [asf_pkg::GAIN_W-1:0]          gain_raw;
  logic [asf_pkg::GAIN_W-1:0]          gain;
  logic [asf_pkg::GAIN_W-1:0]          gain_m1;
  logic [asf_pkg::NFULL_W-1:0]         nfull;
  logic [asf_pkg::FRAC_W-1:0]          rem_f;
  logic [asf_pkg::NUM_W-1:0]           num_full;
  logic [asf_pkg::NUM_W-1:0]           num_rem;
  logic [asf_pkg::NUM_W-1:0]           dividend;
  logic [asf_pkg::WGT_W-1:0]           quotient;
  logic                                div_done;
  logic [asf_pkg::WGT_W-1:0]           tap_w;
  logic [7:0]                          tap_ext;
  logic [7:0]                          nfull_ext;
  logic [asf_pkg::PROD_W-1:0]          c_sum;

  // Per-sample arithmetic
  logic signed [31:0]                  corr;
  logic signed [63:0]                  acc_rnd;
  logic signed [63:0]                  fb_rnd;
  logic signed [31:0]                  v_nxt;
  logic signed [31:0]                  last_nxt;
  logic signed [31:0]                  prior_nxt;
  logic signed [SAMPLE_BITS-1:0]       out_nxt;

  assign t_frac = asf_pkg::unit_frac(trim);
  assign w_frac = asf_pkg::unit_frac(wet);

  // Gain split: full taps, one remainder tap, then zeros
  assign c_clip      = (c_r > asf_pkg::ONE_Q16) ? asf_pkg::ONE_Q16 : c_r;
  assign one_minus_c = asf_pkg::ONE_Q16 - c_clip;
  assign overall     = asf_pkg::DEN_W'({t_frac, 3'b000}) + asf_pkg::DEN_W'({t_frac, 1'b0});
  assign gain_raw    = asf_pkg::GAIN_W'(overall) + asf_pkg::GAIN_W'(c_r);
  assign gain        = (gain_raw < asf_pkg::GAIN_W'(asf_pkg::ONE_Q16)) ?
                       asf_pkg::GAIN_W'(asf_pkg::ONE_Q16) : gain_raw;
  assign gain_m1     = gain - 1'b1;
  assign nfull       = gain_m1[asf_pkg::GAIN_W-1:16];
  assign rem_f       = {1'b0, gain_m1[15:0]} + 1'b1;
  assign den         = (overall < asf_pkg::DEN_W'(asf_pkg::ONE_Q16)) ?
                       asf_pkg::DEN_W'(asf_pkg::ONE_Q16) : overall;
  assign num_full    = {1'b1, 32'b0} + asf_pkg::NUM_W'(den >> 1);
  assign num_rem     = {rem_f, 16'b0} + asf_pkg::NUM_W'(den >> 1);
  assign dividend    = (cmd.div_sel == asf_pkg::DIV_REM) ? num_rem : num_full;

  asf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (den),
    .done     (div_done),
    .quotient (quotient)
  );

  // Weight of the tap under the multiplier
  assign tap_ext   = 8'(tap_idx);
  assign nfull_ext = 8'(nfull_r);
  always_comb begin
    if (tap_ext < nfull_ext) begin
      tap_w = wfull_r;
    end else if (tap_ext == nfull_ext) begin
      tap_w = wrem_r;
    end else begin
      tap_w = '0;
    end
  end

  // Select multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul_sel)
      asf_pkg::MS_TAP: begin
        mul_a = asf_pkg::MA_W'(line_r[tap_idx]);
        mul_b = {1'b0, tap_w};
      end
      asf_pkg::MS_FB: begin
        mul_a = asf_pkg::MA_W'(v_r);
        mul_b = {1'b0, ff_r};
      end
      asf_pkg::MS_MIXL: begin
        mul_a = asf_pkg::MA_W'(last_r);
        mul_b = {1'b0, w_frac};
      end
      asf_pkg::MS_MIXX: begin
        mul_a = asf_pkg::MA_W'(x_r);
        mul_b = {1'b0, asf_pkg::ONE_Q16 - w_frac};
      end
      asf_pkg::MS_WW: begin
        mul_a = asf_pkg::MA_W'(w_frac);
        mul_b = {1'b0, w_frac};
      end
      asf_pkg::MS_W3: begin
        mul_a = asf_pkg::MA_W'(w2_r);
        mul_b = {1'b0, w_frac};
      end
      asf_pkg::MS_CK: begin
        mul_a = asf_pkg::WET_CUBE_K;
        mul_b = {1'b0, w3_r};
      end
      asf_pkg::MS_TT: begin
        mul_a = asf_pkg::MA_W'(t_frac);
        mul_b = {1'b0, one_minus_c};
      end
      asf_pkg::MS_FF: begin
        mul_a = asf_pkg::MA_W'(tt_r);
        mul_b = {1'b0, tt_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_c = mul_a * mul_b;

  // Rounding, saturation and state updates
  assign corr      = asf_pkg::sat32(64'(prior_r) - 64'(last_r) + 64'(sample_in));
  assign acc_rnd   = (64'(acc_r) + 64'sd32768) >>> 16;
  assign fb_rnd    = (64'(prod_r) + 64'sd32768) >>> 16;
  assign v_nxt     = asf_pkg::sat32(64'(prior_r) + acc_rnd);
  assign last_nxt  = asf_pkg::sat32(64'(last_r) + 64'(v_r));
  assign prior_nxt = asf_pkg::sat32(-fb_rnd);
  assign c_sum     = prod_r + asf_pkg::PROD_W'(24'd8388608);

  always_comb begin
    if (acc_rnd > OUT_MAX) begin
      out_nxt = OUT_MAX[SAMPLE_BITS-1:0];
    end else if (acc_rnd < OUT_MIN) begin
      out_nxt = OUT_MIN[SAMPLE_BITS-1:0];
    end else begin
      out_nxt = acc_rnd[SAMPLE_BITS-1:0];
    end
  end

  // Filter state with reset values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAPS; i++) begin
        line_r[i] <= '0;
      end
      last_r  <= '0;
      prior_r <= '0;
      dst_d_r <= asf_pkg::DST_NONE;
    end else begin
      dst_d_r <= cmd.dst;
      if (cmd.load_sample) begin
        line_r[0] <= corr;
        for (int i = 1; i < TAPS; i++) begin
          line_r[i] <= line_r[i-1];
        end
      end
      if (cmd.upd_last) begin
        last_r <= last_nxt;
      end
      if (dst_d_r == asf_pkg::DST_PRIOR) begin
        prior_r <= prior_nxt;
      end
    end
  end

  // Product register, accumulator and coefficient capture
  always_ff @(posedge clk) begin
    prod_r <= prod_c;
    unique case (dst_d_r)
      asf_pkg::DST_LOAD: acc_r <= asf_pkg::ACC_W'(prod_r);
      asf_pkg::DST_ADD:  acc_r <= acc_r + asf_pkg::ACC_W'(prod_r);
      asf_pkg::DST_W2:   w2_r  <= prod_r[32:16];
      asf_pkg::DST_W3:   w3_r  <= prod_r[32:16];
      asf_pkg::DST_C:    c_r   <= c_sum[40:24];
      asf_pkg::DST_TT:   tt_r  <= prod_r[32:16];
      asf_pkg::DST_FF:   ff_r  <= prod_r[32:16];
      default: begin
      end
    endcase
    if (cmd.load_sample) begin
      x_r <= sample_in;
    end
    if (cmd.upd_vel) begin
      v_r <= v_nxt;
    end
    if (cmd.out_load) begin
      out_r <= out_nxt;
    end
    if (cmd.div_start) begin
      div_sel_r <= cmd.div_sel;
      nfull_r   <= nfull;
    end
    if (div_done) begin
      if (div_sel_r == asf_pkg::DIV_REM) begin
        wrem_r <= quotient;
      end else begin
        wfull_r <= quotient;
      end
    end
  end

  assign status.div_done = div_done;
  assign sample_out      = out_r;

endmodule

`default_nettype wire

>>> hdl/asf_ctrl.sv
// Controller: sequences coefficient computation and the per-sample multiply schedule,
// and holds the output valid flag. Depends on asf_pkg.
`default_nettype none

module asf_ctrl #(
  parameter int TAPS = 20
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_wr,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     out_ready,
  output logic                          out_valid,
  input  wire asf_pkg::dp_status_t      status,
  output asf_pkg::dp_cmd_t              cmd,
  output logic [$clog2(TAPS)-1:0]       tap_idx
);

  localparam int TAP_IW = $clog2(TAPS);

  localparam logic [3:0] ST_COEF  = 4'd0;
  localparam logic [3:0] ST_DIVF  = 4'd1;
  localparam logic [3:0] ST_DIVFW = 4'd2;
  localparam logic [3:0] ST_DIVR  = 4'd3;
  localparam logic [3:0] ST_DIVRW = 4'd4;
  localparam logic [3:0] ST_IDLE  = 4'd5;
  localparam logic [3:0] ST_MAC   = 4'd6;
  localparam logic [3:0] ST_VEL   = 4'd7;
  localparam logic [3:0] ST_UPD1  = 4'd8;
  localparam logic [3:0] ST_UPD2  = 4'd9;
  localparam logic [3:0] ST_MIXL  = 4'd10;
  localparam logic [3:0] ST_MIXX  = 4'd11;
  localparam logic [3:0] ST_MIXW  = 4'd12;
  localparam logic [3:0] ST_OUT   = 4'd13;

  logic [3:0]                  state_r;
  logic [3:0]                  state_nxt;
  logic [asf_pkg::STEP_W-1:0]  step_r;
  logic [asf_pkg::STEP_W-1:0]  step_nxt;
  logic [TAP_IW-1:0]           tap_r;
  logic [TAP_IW-1:0]           tap_nxt;
  logic                        out_valid_r;
  logic                        out_free;
  logic                        in_fire;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    tap_nxt   = tap_r;
    cmd       = '0;
    cmd.mul_sel = asf_pkg::MS_NONE;
    cmd.dst     = asf_pkg::DST_NONE;
    unique case (state_r)
      ST_COEF: begin
        unique case (step_r)
          asf_pkg::STEP_W'(0): begin
            cmd.mul_sel = asf_pkg::MS_WW;
            cmd.dst     = asf_pkg::DST_W2;
          end
          asf_pkg::STEP_W'(2): begin
            cmd.mul_sel = asf_pkg::MS_W3;
            cmd.dst     = asf_pkg::DST_W3;
          end
          asf_pkg::STEP_W'(4): begin
            cmd.mul_sel = asf_pkg::MS_CK;
            cmd.dst     = asf_pkg::DST_C;
          end
          asf_pkg::STEP_W'(6): begin
            cmd.mul_sel = asf_pkg::MS_TT;
            cmd.dst     = asf_pkg::DST_TT;
          end
          asf_pkg::STEP_W'(8): begin
            cmd.mul_sel = asf_pkg::MS_FF;
            cmd.dst     = asf_pkg::DST_FF;
          end
          default: begin
            cmd.mul_sel = asf_pkg::MS_NONE;
          end
        endcase
        if (step_r == asf_pkg::STEP_W'(asf_pkg::COEF_STEPS - 1)) begin
          state_nxt = ST_DIVF;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_DIVF: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = asf_pkg::DIV_FULL;
        state_nxt     = ST_DIVFW;
      end
      ST_DIVFW: begin
        if (status.div_done) begin
          state_nxt = ST_DIVR;
        end
      end
      ST_DIVR: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = asf_pkg::DIV_REM;
        state_nxt     = ST_DIVRW;
      end
      ST_DIVRW: begin
        if (status.div_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_sample = 1'b1;
          tap_nxt         = '0;
          state_nxt       = ST_MAC;
        end
      end
      ST_MAC: begin
        cmd.mul_sel = asf_pkg::MS_TAP;
        cmd.dst     = (tap_r == '0) ? asf_pkg::DST_LOAD : asf_pkg::DST_ADD;
        if (tap_r == TAP_IW'(TAPS - 1)) begin
          state_nxt = ST_VEL;
        end else begin
          tap_nxt = tap_r + 1'b1;
        end
      end
      ST_VEL: begin
        state_nxt = ST_UPD1;
      end
      ST_UPD1: begin
        cmd.upd_vel = 1'b1;
        state_nxt   = ST_UPD2;
      end
      ST_UPD2: begin
        cmd.upd_last = 1'b1;
        cmd.mul_sel  = asf_pkg::MS_FB;
        cmd.dst      = asf_pkg::DST_PRIOR;
        state_nxt    = ST_MIXL;
      end
      ST_MIXL: begin
        cmd.mul_sel = asf_pkg::MS_MIXL;
        cmd.dst     = asf_pkg::DST_LOAD;
        state_nxt   = ST_MIXX;
      end
      ST_MIXX: begin
        cmd.mul_sel = asf_pkg::MS_MIXX;
        cmd.dst     = asf_pkg::DST_ADD;
        state_nxt   = ST_MIXW;
      end
      ST_MIXW: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_COEF;
        step_nxt  = '0;
      end
    endcase
    // Restart the coefficient computation after any register write
    if (cfg_wr) begin
      state_nxt = ST_COEF;
      step_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_COEF;
      step_r      <= '0;
      tap_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      tap_r   <= tap_nxt;
      // Hold the result until the output transaction completes
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign tap_idx   = tap_r;

  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> (state_r == ST_COEF) && (step_r == '0))
    else $error("coefficient sequence did not restart after a register write");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("second input accepted while an item is in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) && out_valid_r && !out_ready && !cfg_wr
    |=> (state_r == ST_OUT) && out_valid_r)
    else $error("pending result overwritten or dropped");

endmodule

`default_nettype wire

>>> hdl/acceleration_smoothing_filter_unit.sv
// The single shared multiplier steps through the taps one per cycle, then does the feedback and
// the wet/dry mix; a new sample is taken only after the result has been loaded into the output
// register, which waits while a previous result is still pending on the result channel.
// After reset and after each register write the weights are recomputed (two 33-step
// divisions) with in_ready low. Reset is synchronous, active low, clears the change line,
// last and prior state, and sets trim to zero and wet to full.
`default_nettype none

module acceleration_smoothing_filter_unit #(
  parameter int TAPS        = 20,
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Input channel
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0]   in_sample_in,
  // Result channel
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic signed [SAMPLE_BITS-1:0]        out_sample_out,
  // Register port
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [asf_pkg::PADDR_W-1:0]     paddr,
  input  wire logic [31:0]                     pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  logic [15:0]          trim_r;
  logic [15:0]          wet_r;
  logic                 cfg_wr;
  logic                 reg_idx;
  asf_pkg::dp_cmd_t     cmd;
  asf_pkg::dp_status_t  status;
  logic [$clog2(TAPS)-1:0] tap_idx;

  // Register write on the access phase of a write transaction
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trim_r <= 16'h0000;
      wet_r  <= 16'hFFFF;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        asf_pkg::REG_TRIM: trim_r <= pwdata[15:0];
        asf_pkg::REG_WET:  wet_r  <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // Read back
  assign prdata = {16'b0, (reg_idx == asf_pkg::REG_WET) ? wet_r : trim_r};

  asf_ctrl #(
    .TAPS (TAPS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_wr),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .status    (status),
    .cmd       (cmd),
    .tap_idx   (tap_idx)
  );

  asf_dp #(
    .TAPS        (TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .tap_idx    (tap_idx),
    .trim       (trim_r),
    .wet        (wet_r),
    .sample_in  (in_sample_in),
    .status     (status),
    .sample_out (out_sample_out)
  );

endmodule

`default_nettype wire
